// ----- src/hcl_pkg.sv -----
// shared types and constants of the handle cache
package hcl_pkg;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 64;
  localparam int SLOT_W   = 6;
  localparam int HANDLE_W = 32;
  localparam int STAMP_W  = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OP_W-1:0] OP_BIND    = 3'd3;
  localparam logic [OP_W-1:0] OP_MARK    = 3'd4;

  // node number of the root, answered without a search
  localparam logic [KEY_W-1:0] ROOT_KEY = 64'd1;

  // one result item
  typedef struct packed {
    logic                status;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot_out;
    logic                was_opened;
    logic                is_directory;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
  } rsp_t;

  // flags from the shared comparator
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ----- src/hcl_ifs.sv -----
// request and result channel interfaces of the handle cache

interface hcl_req_if import hcl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  key;
  logic [SLOT_W-1:0] slot_index;
  logic              dir_flag;

  modport source (output valid, operation, key, slot_index, dir_flag, input ready);
  modport sink   (input valid, operation, key, slot_index, dir_flag, output ready);
endinterface

interface hcl_rsp_if import hcl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                status;
  logic [HANDLE_W-1:0] handle;
  logic [SLOT_W-1:0]   slot_out;
  logic                was_opened;
  logic                is_directory;
  logic                evicted;
  logic [HANDLE_W-1:0] evicted_handle;

  modport source (output valid, status, handle, slot_out, was_opened, is_directory,
                  evicted, evicted_handle, input ready);
  modport sink   (input valid, status, handle, slot_out, was_opened, is_directory,
                  evicted, evicted_handle, output ready);
endinterface

// ----- src/hcl_cmp.sv -----
// shared 64-bit comparator for key match and stamp ordering
module hcl_cmp import hcl_pkg::*; (
  input  logic               sel_key,
  input  logic [KEY_W-1:0]   key_q,
  input  logic [KEY_W-1:0]   key_ref,
  input  logic [STAMP_W-1:0] stamp_q,
  input  logic [STAMP_W-1:0] least,
  output cmp_res_t           res
);

  logic [KEY_W-1:0] op_a;
  logic [KEY_W-1:0] op_b;

  // operand select: key against request, or stamp against running minimum
  assign op_a = sel_key ? key_q   : stamp_q;
  assign op_b = sel_key ? key_ref : least;

  assign res.eq = (op_a == op_b);
  assign res.lt = (op_a <  op_b);

endmodule

// ----- src/handle_cache_lru.sv -----
// handle cache top level: fully associative table with lru replacement
//
//   channel   dir   handshake              payload
//   in_ch     in    valid/ready            operation, key, slot_index, dir_flag
//   out_ch    out   valid/ready            status, handle, slot_out, was_opened,
//                                          is_directory, evicted, evicted_handle
//
// lookup (other than the root key) and allocate scan the table one entry per
// cycle through the key, handle and stamp memories.
// release, bind, mark-open and the root lookup skip the scan and go straight to the done state.
// reset is synchronous; the table needs no clearing pass after it.
// a new request is taken while the previous result waits in the output register;
// a finished result waits for that register to free up.
module handle_cache_lru import hcl_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  hcl_req_if.sink   in_ch,
  hcl_rsp_if.source out_ch
);

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam logic [CNTW-1:0] CNT_END  = CNTW'(ENTRIES);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // control state
  logic [1:0]          state_r, state_nxt;
  logic [CNTW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic                cv_r, cv_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STAMP_W-1:0]  use_clock_r, use_clock_nxt;
  logic [HANDLE_W-1:0] next_handle_r, next_handle_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [ENTRIES-1:0]  opened_r, opened_nxt;
  logic [ENTRIES-1:0]  dir_r, dir_nxt;

  // request and scan payload
  logic [OP_W-1:0]     op_r;
  logic [KEY_W-1:0]    key_r;
  logic [IDXW-1:0]     cmp_idx_r;
  logic [STAMP_W-1:0]  least_r, least_nxt;
  logic [IDXW-1:0]     pick_r, pick_nxt;
  logic [HANDLE_W-1:0] least_handle_r, least_handle_nxt;
  rsp_t                res_r, res_nxt;
  rsp_t                out_data_r;

  // table memories
  logic [KEY_W-1:0]    key_mem    [ENTRIES];
  logic [HANDLE_W-1:0] handle_mem [ENTRIES];
  logic [STAMP_W-1:0]  stamp_mem  [ENTRIES];
  logic [KEY_W-1:0]    key_q_r;
  logic [HANDLE_W-1:0] handle_q_r;
  logic [STAMP_W-1:0]  stamp_q_r;

  // memory ports
  logic                key_we;
  logic [IDXW-1:0]     key_wa;
  logic [KEY_W-1:0]    key_wd;
  logic                handle_we;
  logic [IDXW-1:0]     handle_wa;
  logic                stamp_we;
  logic [IDXW-1:0]     stamp_wa;
  logic [STAMP_W-1:0]  stamp_wd;
  logic                rd_en;
  logic [IDXW-1:0]     rd_idx;

  logic                in_fire;
  logic                out_load;
  logic                slot_ok;
  logic [IDXW-1:0]     slot_idx;
  logic                lookup_hit;
  logic                alloc_go;
  logic [IDXW-1:0]     alloc_pick;
  logic                alloc_evict;
  logic [HANDLE_W-1:0] alloc_eh;
  logic                take;
  cmp_res_t            cmp;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign slot_ok     = int'(in_ch.slot_index) < ENTRIES;
  assign slot_idx    = IDXW'(in_ch.slot_index);
  assign rd_idx      = rd_cnt_r[IDXW-1:0];

  // shared comparator
  hcl_cmp u_cmp (
    .sel_key (op_r == OP_LOOKUP),
    .key_q   (key_q_r),
    .key_ref (key_r),
    .stamp_q (stamp_q_r),
    .least   (least_r),
    .res     (cmp)
  );

  // sequencer and table update
  always_comb begin
    state_nxt        = state_r;
    rd_cnt_nxt       = rd_cnt_r;
    cv_nxt           = 1'b0;
    use_clock_nxt    = use_clock_r;
    next_handle_nxt  = next_handle_r;
    valid_nxt        = valid_r;
    opened_nxt       = opened_r;
    dir_nxt          = dir_r;
    least_nxt        = least_r;
    pick_nxt         = pick_r;
    least_handle_nxt = least_handle_r;
    res_nxt          = res_r;
    key_we           = 1'b0;
    key_wa           = slot_idx;
    key_wd           = in_ch.key;
    handle_we        = 1'b0;
    handle_wa        = cmp_idx_r;
    stamp_we         = 1'b0;
    stamp_wa         = cmp_idx_r;
    stamp_wd         = use_clock_r + 64'd1;
    rd_en            = 1'b0;
    lookup_hit       = 1'b0;
    alloc_go         = 1'b0;
    alloc_pick       = cmp_idx_r;
    alloc_evict      = 1'b0;
    alloc_eh         = '0;
    take             = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt    = '0;
          rd_cnt_nxt = '0;
          unique case (in_ch.operation) inside
            OP_LOOKUP: begin
              state_nxt = (in_ch.key == ROOT_KEY) ? S_DONE : S_SCAN;
            end
            OP_ALLOC: begin
              state_nxt = S_SCAN;
            end
            OP_RELEASE, OP_BIND, OP_MARK: begin
              state_nxt = S_DONE;
              if (slot_ok) begin
                res_nxt.slot_out = in_ch.slot_index;
                unique case (in_ch.operation)
                  OP_RELEASE: valid_nxt[slot_idx] = 1'b0;
                  OP_BIND: begin
                    key_we            = 1'b1;
                    dir_nxt[slot_idx] = in_ch.dir_flag;
                  end
                  default: begin
                    res_nxt.was_opened   = opened_r[slot_idx];
                    res_nxt.is_directory = dir_r[slot_idx];
                    opened_nxt[slot_idx] = 1'b1;
                  end
                endcase
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        // issue the next table read
        if (rd_cnt_r < CNT_END) begin
          rd_en      = 1'b1;
          rd_cnt_nxt = rd_cnt_r + 1'b1;
          cv_nxt     = 1'b1;
        end
        // judge the entry whose data just came back
        if (cv_r) begin
          if (op_r == OP_LOOKUP) begin
            if (valid_r[cmp_idx_r] && cmp.eq) begin
              lookup_hit           = 1'b1;
              use_clock_nxt        = use_clock_r + 64'd1;
              stamp_we             = 1'b1;
              res_nxt.handle       = handle_q_r;
              res_nxt.slot_out     = SLOT_W'(cmp_idx_r);
              res_nxt.was_opened   = opened_r[cmp_idx_r];
              res_nxt.is_directory = dir_r[cmp_idx_r];
              state_nxt            = S_DONE;
              cv_nxt               = 1'b0;
            end else if (cmp_idx_r == LAST_IDX) begin
              res_nxt.status = 1'b1;
              state_nxt      = S_DONE;
              cv_nxt         = 1'b0;
            end
          end else if (!valid_r[cmp_idx_r]) begin
            // first free slot
            alloc_go = 1'b1;
          end else begin
            // running minimum of stamps, earliest slot wins ties
            take = (cmp_idx_r == '0) || cmp.lt;
            if (take) begin
              least_nxt        = stamp_q_r;
              pick_nxt         = cmp_idx_r;
              least_handle_nxt = handle_q_r;
            end
            if (cmp_idx_r == LAST_IDX) begin
              alloc_go    = 1'b1;
              alloc_evict = 1'b1;
              alloc_pick  = take ? cmp_idx_r : pick_r;
              alloc_eh    = take ? handle_q_r : least_handle_r;
            end
          end
        end
        // allocate commit
        if (alloc_go) begin
          key_we                 = 1'b1;
          key_wa                 = alloc_pick;
          key_wd                 = key_r;
          handle_we              = 1'b1;
          handle_wa              = alloc_pick;
          stamp_we               = 1'b1;
          stamp_wa               = alloc_pick;
          use_clock_nxt          = use_clock_r + 64'd1;
          next_handle_nxt        = next_handle_r + 32'd1;
          valid_nxt[alloc_pick]  = 1'b1;
          opened_nxt[alloc_pick] = 1'b0;
          res_nxt.handle         = next_handle_r;
          res_nxt.slot_out       = SLOT_W'(alloc_pick);
          res_nxt.evicted        = alloc_evict;
          res_nxt.evicted_handle = alloc_eh;
          state_nxt              = S_DONE;
          cv_nxt                 = 1'b0;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rd_cnt_r      <= '0;
      cv_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      use_clock_r   <= '0;
      next_handle_r <= 32'd1;
      valid_r       <= '0;
      opened_r      <= '0;
      dir_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      rd_cnt_r      <= rd_cnt_nxt;
      cv_r          <= cv_nxt;
      out_valid_r   <= out_valid_nxt;
      use_clock_r   <= use_clock_nxt;
      next_handle_r <= next_handle_nxt;
      valid_r       <= valid_nxt;
      opened_r      <= opened_nxt;
      dir_r         <= dir_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.operation;
      key_r <= in_ch.key;
    end
    if (rd_en) begin
      cmp_idx_r <= rd_idx;
    end
    least_r        <= least_nxt;
    pick_r         <= pick_nxt;
    least_handle_r <= least_handle_nxt;
    res_r          <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // table memories, registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (handle_we) begin
      handle_mem[handle_wa] <= next_handle_r;
    end
    if (stamp_we) begin
      stamp_mem[stamp_wa] <= stamp_wd;
    end
    if (rd_en) begin
      key_q_r    <= key_mem[rd_idx];
      handle_q_r <= handle_mem[rd_idx];
      stamp_q_r  <= stamp_mem[rd_idx];
    end
  end

  // result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_data_r.status;
  assign out_ch.handle         = out_data_r.handle;
  assign out_ch.slot_out       = out_data_r.slot_out;
  assign out_ch.was_opened     = out_data_r.was_opened;
  assign out_ch.is_directory   = out_data_r.is_directory;
  assign out_ch.evicted        = out_data_r.evicted;
  assign out_ch.evicted_handle = out_data_r.evicted_handle;

`ifndef NO_ASSERTIONS
  // compare stage only carries data while scanning
  a_cv_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cv_r |-> state_r == S_SCAN)
    else $error("compare stage active outside scan");

  // an allocated slot is valid afterwards
  a_alloc_valid: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_go |=> valid_r[$past(alloc_pick)])
    else $error("allocated slot not valid");

  // handle counter advances by one per allocate
  a_handle_step: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_go |=> next_handle_r == $past(next_handle_r) + 32'd1)
    else $error("handle counter did not advance");

  // use clock moves only on a hit or an allocate
  a_clock_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(alloc_go || lookup_hit) |=> use_clock_r == $past(use_clock_r))
    else $error("use clock changed without a stamp update");
`endif

endmodule
